@@ rtl/core/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types and constants for the resource descriptor scanner.
// ----------------------------------------------------------------------------
package rds_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [7:0] END_TAG        = 8'h79;
    localparam logic [3:0] SMALL_IRQ_KIND = 4'h4;
    localparam logic [6:0] EXT_IRQ_TAG    = 7'h09;
    localparam logic [6:0] SERIAL_TAG     = 7'h0E;
    localparam logic [7:0] BUS_KIND_ADDR  = 8'h01;

    localparam logic [15:0] SMALL_IRQ_MIN_LEN = 16'd2;
    localparam logic [15:0] EXT_IRQ_MIN_LEN   = 16'd10;
    localparam logic [15:0] SERIAL_MIN_LEN    = 16'd11;
    localparam logic [15:0] SER_TLEN_MIN      = 16'd4;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_LEN_LO = 5'b00010,
        PH_LEN_HI = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_SM_IRQ  = 2'd1,
        KIND_EXT_IRQ = 2'd2,
        KIND_SERIAL  = 2'd3
    } t_kind;

    // one byte handed from the input register to the scanner
    typedef struct packed {
        logic       take;
        logic [7:0] data;
        logic       last;
    } t_scan_in;

    typedef struct packed {
        logic [6:0]  bus_address;
        logic        found_bus_address;
        logic        irq_trigger;
        logic        irq_polarity;
        logic [31:0] interrupt_number;
        logic        irq_found;
    } t_result;

endpackage

@@ rtl/core/rds_in_reg.sv @@
// ----------------------------------------------------------------------------
// rds_in_reg
// Input register stage: holds one byte transfer until the scanner takes it.
// ----------------------------------------------------------------------------
module rds_in_reg
    import rds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  logic       i_out_free,
    output t_scan_in   o_scan
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       w_adv;

    // a last byte may move on only when the result register can load
    assign w_adv   = r_valid && (!r_last || i_out_free);
    assign o_ready = !r_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_scan.take = w_adv;
    assign o_scan.data = r_data;
    assign o_scan.last = r_last;

endmodule

@@ rtl/core/rds_scan.sv @@
// ----------------------------------------------------------------------------
// rds_scan
// Descriptor parser: tracks header and body bytes, captures pending fields
// and commits them when a descriptor's body completes.
// ----------------------------------------------------------------------------
module rds_scan
    import rds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_scan_in i_in,
    output t_result  o_result
);

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [15:0] r_len, n_len;
    logic [15:0] r_off, n_off;
    logic [15:0] r_mask, n_mask;
    logic [7:0]  r_info, n_info;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_num, n_num;
    logic [7:0]  r_bus_kind, n_bus_kind;
    logic [15:0] r_ser_tlen, n_ser_tlen;
    logic [6:0]  r_addr, n_addr;
    t_result     r_comm, n_comm;
    logic        w_commit;
    logic [3:0]  w_low_bit;

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_len      = r_len;
        n_off      = r_off;
        n_mask     = r_mask;
        n_info     = r_info;
        n_count    = r_count;
        n_num      = r_num;
        n_bus_kind = r_bus_kind;
        n_ser_tlen = r_ser_tlen;
        n_addr     = r_addr;
        w_commit   = 1'b0;
        if (i_in.take) begin
            case (r_phase)
                PH_TAG: begin
                    if (i_in.data == END_TAG) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_len      = '0;
                        n_off      = '0;
                        n_mask     = '0;
                        n_info     = '0;
                        n_count    = '0;
                        n_num      = '0;
                        n_bus_kind = '0;
                        n_ser_tlen = '0;
                        n_addr     = '0;
                        if (!i_in.data[7]) begin
                            n_kind = (i_in.data[6:3] == SMALL_IRQ_KIND) ? KIND_SM_IRQ
                                                                        : KIND_NONE;
                            n_len  = {13'd0, i_in.data[2:0]};
                            if (i_in.data[2:0] == 3'd0) begin
                                w_commit = 1'b1;
                                n_phase  = PH_TAG;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            if (i_in.data[6:0] == EXT_IRQ_TAG) begin
                                n_kind = KIND_EXT_IRQ;
                            end else if (i_in.data[6:0] == SERIAL_TAG) begin
                                n_kind = KIND_SERIAL;
                            end else begin
                                n_kind = KIND_NONE;
                            end
                            n_phase = PH_LEN_LO;
                        end
                    end
                end
                PH_LEN_LO: begin
                    n_len   = {8'd0, i_in.data};
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = {i_in.data, r_len[7:0]};
                    if (n_len == 16'd0) begin
                        w_commit = 1'b1;
                        n_phase  = PH_TAG;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    case (r_kind)
                        KIND_SM_IRQ: begin
                            if (r_off == 16'd0) n_mask[7:0]  = i_in.data;
                            if (r_off == 16'd1) n_mask[15:8] = i_in.data;
                            if (r_off == 16'd2) n_info       = i_in.data;
                        end
                        KIND_EXT_IRQ: begin
                            if (r_off == 16'd1) n_mask  = {8'd0, i_in.data};
                            if (r_off == 16'd2) n_count = i_in.data;
                            if (r_off == 16'd3) n_num[7:0]   = r_num[7:0]   | i_in.data;
                            if (r_off == 16'd4) n_num[15:8]  = r_num[15:8]  | i_in.data;
                            if (r_off == 16'd5) n_num[23:16] = r_num[23:16] | i_in.data;
                            if (r_off == 16'd6) n_num[31:24] = r_num[31:24] | i_in.data;
                        end
                        KIND_SERIAL: begin
                            if (r_off == 16'd0)  n_bus_kind       = i_in.data;
                            if (r_off == 16'd4)  n_ser_tlen[7:0]  = i_in.data;
                            if (r_off == 16'd5)  n_ser_tlen[15:8] = i_in.data;
                            if (r_off == 16'd10) n_addr           = i_in.data[6:0];
                        end
                        default: begin
                        end
                    endcase
                    n_off = r_off + 16'd1;
                    if (n_off >= r_len) begin
                        w_commit = 1'b1;
                        n_phase  = PH_TAG;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end
    end

    // lowest set bit of the interrupt mask
    always_comb begin
        w_low_bit = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (n_mask[i]) w_low_bit = 4'(i);
        end
    end

    always_comb begin
        n_comm = r_comm;
        if (w_commit) begin
            case (n_kind)
                KIND_SM_IRQ: begin
                    if (n_len >= SMALL_IRQ_MIN_LEN && n_mask != 16'd0) begin
                        n_comm.interrupt_number = {28'd0, w_low_bit};
                        n_comm.irq_polarity     = n_info[1];
                        n_comm.irq_trigger      = n_info[0];
                        n_comm.irq_found        = 1'b1;
                    end
                end
                KIND_EXT_IRQ: begin
                    if (n_len >= EXT_IRQ_MIN_LEN && n_count != 8'd0) begin
                        n_comm.interrupt_number = n_num;
                        n_comm.irq_polarity     = n_mask[1];
                        n_comm.irq_trigger      = n_mask[0];
                        n_comm.irq_found        = 1'b1;
                    end
                end
                KIND_SERIAL: begin
                    if (n_len >= SERIAL_MIN_LEN && n_bus_kind == BUS_KIND_ADDR &&
                        n_ser_tlen >= SER_TLEN_MIN) begin
                        n_comm.bus_address       = n_addr;
                        n_comm.found_bus_address = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = n_comm;

    // clear everything after the last byte of a template
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_in.take && i_in.last)) begin
            r_phase    <= PH_TAG;
            r_kind     <= KIND_NONE;
            r_len      <= '0;
            r_off      <= '0;
            r_mask     <= '0;
            r_info     <= '0;
            r_count    <= '0;
            r_num      <= '0;
            r_bus_kind <= '0;
            r_ser_tlen <= '0;
            r_addr     <= '0;
            r_comm     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_off      <= n_off;
            r_mask     <= n_mask;
            r_info     <= n_info;
            r_count    <= n_count;
            r_num      <= n_num;
            r_bus_kind <= n_bus_kind;
            r_ser_tlen <= n_ser_tlen;
            r_addr     <= n_addr;
            r_comm     <= n_comm;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.take && i_in.last) |=> (r_phase == PH_TAG && r_comm == '0))
        else $error("scan state not cleared after last byte");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(i_in.take && i_in.last)) |=> (r_phase == PH_DONE))
        else $error("scan left end state before last byte");

    a_body_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_off < r_len))
        else $error("body offset beyond body length");

    a_irq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_comm.irq_found |-> (r_comm.interrupt_number == 32'd0 &&
            !r_comm.irq_polarity && !r_comm.irq_trigger))
        else $error("interrupt fields set without a found interrupt");

    a_bus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_comm.found_bus_address |-> (r_comm.bus_address == 7'd0))
        else $error("bus address set without a found address");
`endif

endmodule

@@ rtl/core/rds_out_reg.sv @@
// ----------------------------------------------------------------------------
// rds_out_reg
// Result register: holds one packed result until the master side takes it.
// ----------------------------------------------------------------------------
module rds_out_reg
    import rds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, i_result};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/resource_descriptor_scanner.sv @@
// A last byte's result reaches the master side via the input register and the result register.
// Throughput: one byte per cycle unless stalled; a byte's parse is one registered step.
// Back-pressure on the master side stalls the slave side only once a last byte waits.
// Reset (synchronous, active low) clears the scan state and both handshake stages.
// All scan state also returns to its reset value after each last byte.
// ----------------------------------------------------------------------------
// resource_descriptor_scanner
// Scans a resource template byte stream and reports the captured interrupt
// and bus-address fields once per template.
// ----------------------------------------------------------------------------
module resource_descriptor_scanner
    import rds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic                   i_s_axis_tlast,  // last_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] irq_found, [32:1] interrupt_number, [33] irq_polarity,
    // [34] irq_trigger, [35] found_bus_address, [42:36] bus_address,
    // [47:43] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_scan_in w_scan;
    t_result  w_result;
    logic     w_out_free;

    rds_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_out_free (w_out_free),
        .o_scan     (w_scan)
    );

    rds_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (w_scan),
        .o_result (w_result)
    );

    rds_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_scan.take && w_scan.last),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule
